FILE: hdl/assert_macros.svh
// Assertion helpers for the tty line discipline
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define TCLD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tty line discipline check failed");

// checked on every edge, reset included
`define TCLD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tty line discipline reset check failed");

`endif

FILE: hdl/tcld_pkg.sv
package tcld_pkg;

    localparam int RING_DEPTH_DEF = 4096;
    localparam int LINE_DEPTH_DEF = 1024;

    localparam logic [7:0] C_BS  = 8'd8;
    localparam logic [7:0] C_NL  = 8'd10;
    localparam logic [7:0] C_CR  = 8'd13;
    localparam logic [7:0] C_SP  = 8'd32;
    localparam logic [7:0] C_DEL = 8'd127;

    localparam logic [4:0] MODE_RST  = 5'd31;
    localparam logic [7:0] INTR_RST  = 8'd3;
    localparam logic [7:0] QUIT_RST  = 8'd28;
    localparam logic [7:0] SUSP_RST  = 8'd26;
    localparam logic [7:0] ERASE_RST = 8'd127;
    localparam logic [7:0] EOF_RST   = 8'd4;

    // mode flag bits
    localparam int MF_CRNL_IN  = 0;
    localparam int MF_CRNL_OUT = 1;
    localparam int MF_SIG      = 2;
    localparam int MF_CANON    = 3;
    localparam int MF_ECHO     = 4;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_INTR   = 3'd1;
    localparam logic [2:0] REG_QUIT   = 3'd2;
    localparam logic [2:0] REG_SUSP   = 3'd3;
    localparam logic [2:0] REG_ERASE  = 3'd4;
    localparam logic [2:0] REG_EOF    = 3'd5;
    localparam logic [2:0] REG_TARGET = 3'd6;

    localparam logic [1:0] SIG_INTR = 2'd0;
    localparam logic [1:0] SIG_QUIT = 2'd1;
    localparam logic [1:0] SIG_SUSP = 2'd2;

    typedef enum logic [2:0] {
        KIND_ECHO   = 3'd0,
        KIND_SIGNAL = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_EMPTY  = 3'd3,
        KIND_EOF    = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_CHAR,
        SRC_CR,
        SRC_BS,
        SRC_SP,
        SRC_QDATA
    } t_src;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_POP_DATA,
        ST_POP_EOF,
        ST_POP_EMPTY,
        ST_SIG_OUT,
        ST_ERASE0,
        ST_ERASE1,
        ST_ERASE2,
        ST_ECHO_CR,
        ST_ECHO_C,
        ST_COMMIT_CHK,
        ST_COMMIT_RD,
        ST_COMMIT_WR
    } t_state;

    typedef struct packed {
        logic  latch_in;
        logic  out_load;
        t_kind out_kind;
        t_src  out_src;
        logic  out_last;
        logic  line_push;
        logic  line_pop;
        logic  queue_push_char;
        logic  q_pop_rd;
        logic  eof_clear;
        logic  commit_rd;
        logic  commit_wr;
        logic  commit_end;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic is_sig;
        logic sig_target;
        logic canon;
        logic is_erase;
        logic is_eof;
        logic echo_on;
        logic crnl;
        logic is_nl;
        logic line_empty;
        logic q_empty;
        logic eof_mark;
        logic commit_done;
        logic out_free;
    } t_status;

endpackage

FILE: hdl/tcld_ctrl.sv
module tcld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  tcld_pkg::t_status i_status,
    output tcld_pkg::t_cmd    o_cmd
);

    tcld_pkg::t_state r_state, n_state;
    logic             r_commit, n_commit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tcld_pkg::ST_IDLE;
            r_commit <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_commit <= n_commit;
        end
    end

    assign o_in_stall = (r_state != tcld_pkg::ST_IDLE);

    // next state
    always_comb begin
        n_state  = r_state;
        n_commit = r_commit;
        case (r_state)
            tcld_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tcld_pkg::ST_DECIDE;
                end
            end
            tcld_pkg::ST_DECIDE: begin
                n_commit = 1'b0;
                if (i_status.action) begin
                    if (!i_status.q_empty) begin
                        n_state = tcld_pkg::ST_POP_DATA;
                    end else if (i_status.eof_mark) begin
                        n_state = tcld_pkg::ST_POP_EOF;
                    end else begin
                        n_state = tcld_pkg::ST_POP_EMPTY;
                    end
                end else if (i_status.is_sig) begin
                    n_state = i_status.sig_target ? tcld_pkg::ST_SIG_OUT : tcld_pkg::ST_IDLE;
                end else if (i_status.canon && i_status.is_erase) begin
                    if (!i_status.line_empty && i_status.echo_on) begin
                        n_state = tcld_pkg::ST_ERASE0;
                    end else begin
                        n_state = tcld_pkg::ST_IDLE;
                    end
                end else if (i_status.canon && i_status.is_eof) begin
                    n_state = tcld_pkg::ST_COMMIT_CHK;
                end else begin
                    n_commit = i_status.canon && i_status.is_nl;
                    if (i_status.echo_on) begin
                        n_state = i_status.crnl ? tcld_pkg::ST_ECHO_CR : tcld_pkg::ST_ECHO_C;
                    end else if (i_status.canon && i_status.is_nl) begin
                        n_state = tcld_pkg::ST_COMMIT_CHK;
                    end else begin
                        n_state = tcld_pkg::ST_IDLE;
                    end
                end
            end
            tcld_pkg::ST_POP_DATA, tcld_pkg::ST_POP_EOF, tcld_pkg::ST_POP_EMPTY,
            tcld_pkg::ST_SIG_OUT, tcld_pkg::ST_ERASE2: begin
                if (i_status.out_free) begin
                    n_state = tcld_pkg::ST_IDLE;
                end
            end
            tcld_pkg::ST_ERASE0: begin
                if (i_status.out_free) begin
                    n_state = tcld_pkg::ST_ERASE1;
                end
            end
            tcld_pkg::ST_ERASE1: begin
                if (i_status.out_free) begin
                    n_state = tcld_pkg::ST_ERASE2;
                end
            end
            tcld_pkg::ST_ECHO_CR: begin
                if (i_status.out_free) begin
                    n_state = tcld_pkg::ST_ECHO_C;
                end
            end
            tcld_pkg::ST_ECHO_C: begin
                if (i_status.out_free) begin
                    n_state = r_commit ? tcld_pkg::ST_COMMIT_CHK : tcld_pkg::ST_IDLE;
                end
            end
            tcld_pkg::ST_COMMIT_CHK: begin
                n_state = i_status.commit_done ? tcld_pkg::ST_IDLE : tcld_pkg::ST_COMMIT_RD;
            end
            tcld_pkg::ST_COMMIT_RD: begin
                n_state = tcld_pkg::ST_COMMIT_WR;
            end
            tcld_pkg::ST_COMMIT_WR: begin
                n_state = tcld_pkg::ST_COMMIT_CHK;
            end
            default: begin
                n_state = tcld_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.out_kind = tcld_pkg::KIND_ECHO;
        o_cmd.out_src  = tcld_pkg::SRC_ZERO;
        case (r_state)
            tcld_pkg::ST_IDLE: begin
                o_cmd.latch_in = i_in_valid;
            end
            tcld_pkg::ST_DECIDE: begin
                if (i_status.action) begin
                    o_cmd.q_pop_rd  = !i_status.q_empty;
                    o_cmd.eof_clear = i_status.q_empty && i_status.eof_mark;
                end else if (i_status.is_sig) begin
                    o_cmd.q_pop_rd = 1'b0;
                end else if (i_status.canon) begin
                    if (i_status.is_erase) begin
                        o_cmd.line_pop = !i_status.line_empty;
                    end else if (!i_status.is_eof) begin
                        o_cmd.line_push = 1'b1;
                    end
                end else begin
                    o_cmd.queue_push_char = 1'b1;
                end
            end
            tcld_pkg::ST_POP_DATA: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_kind = tcld_pkg::KIND_DATA;
                o_cmd.out_src  = tcld_pkg::SRC_QDATA;
                o_cmd.out_last = 1'b1;
            end
            tcld_pkg::ST_POP_EOF: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_kind = tcld_pkg::KIND_EOF;
                o_cmd.out_last = 1'b1;
            end
            tcld_pkg::ST_POP_EMPTY: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_kind = tcld_pkg::KIND_EMPTY;
                o_cmd.out_last = 1'b1;
            end
            tcld_pkg::ST_SIG_OUT: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_kind = tcld_pkg::KIND_SIGNAL;
                o_cmd.out_last = 1'b1;
            end
            tcld_pkg::ST_ERASE0: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_src  = tcld_pkg::SRC_BS;
            end
            tcld_pkg::ST_ERASE1: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_src  = tcld_pkg::SRC_SP;
            end
            tcld_pkg::ST_ERASE2: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_src  = tcld_pkg::SRC_BS;
                o_cmd.out_last = 1'b1;
            end
            tcld_pkg::ST_ECHO_CR: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_src  = tcld_pkg::SRC_CR;
            end
            tcld_pkg::ST_ECHO_C: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_src  = tcld_pkg::SRC_CHAR;
                o_cmd.out_last = 1'b1;
            end
            tcld_pkg::ST_COMMIT_CHK: begin
                o_cmd.commit_end = i_status.commit_done;
            end
            tcld_pkg::ST_COMMIT_RD: begin
                o_cmd.commit_rd = 1'b1;
            end
            tcld_pkg::ST_COMMIT_WR: begin
                o_cmd.commit_wr = 1'b1;
            end
            default: begin
                o_cmd.out_load = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/tcld_dp.sv
module tcld_dp #(
    parameter int RING_DEPTH = tcld_pkg::RING_DEPTH_DEF,
    parameter int LINE_DEPTH = tcld_pkg::LINE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_action,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [2:0]        o_kind,
    output logic [7:0]        o_data_byte,
    output logic [1:0]        o_signal_code,
    output logic              o_last,
    input  tcld_pkg::t_cmd    i_cmd,
    output tcld_pkg::t_status o_status
);

    localparam int QW  = $clog2(RING_DEPTH);
    localparam int LIW = $clog2(LINE_DEPTH);
    localparam int LNW = $clog2(LINE_DEPTH + 1);
    localparam logic [QW-1:0]  QLAST    = QW'(RING_DEPTH - 1);
    localparam logic [LNW-1:0] LINE_MAX = LNW'(LINE_DEPTH);

    // configuration
    logic [4:0] r_mode;
    logic [7:0] r_intr, r_quit, r_susp, r_erase, r_eof;
    logic       r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= tcld_pkg::MODE_RST;
            r_intr   <= tcld_pkg::INTR_RST;
            r_quit   <= tcld_pkg::QUIT_RST;
            r_susp   <= tcld_pkg::SUSP_RST;
            r_erase  <= tcld_pkg::ERASE_RST;
            r_eof    <= tcld_pkg::EOF_RST;
            r_target <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tcld_pkg::REG_MODE:   r_mode   <= i_cfg_data[4:0];
                tcld_pkg::REG_INTR:   r_intr   <= i_cfg_data;
                tcld_pkg::REG_QUIT:   r_quit   <= i_cfg_data;
                tcld_pkg::REG_SUSP:   r_susp   <= i_cfg_data;
                tcld_pkg::REG_ERASE:  r_erase  <= i_cfg_data;
                tcld_pkg::REG_EOF:    r_eof    <= i_cfg_data;
                tcld_pkg::REG_TARGET: r_target <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // latched word, CR already mapped
    logic       r_act;
    logic [7:0] r_c;
    logic [7:0] n_c;

    assign n_c = (r_mode[tcld_pkg::MF_CRNL_IN] && i_rx_byte == tcld_pkg::C_CR)
                 ? tcld_pkg::C_NL : i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_act <= i_action;
            r_c   <= n_c;
        end
    end

    logic       m_intr, m_quit, m_susp;
    logic [1:0] sig_code;

    assign m_intr   = (r_c == r_intr);
    assign m_quit   = (r_c == r_quit);
    assign m_susp   = (r_c == r_susp);
    assign sig_code = m_intr ? tcld_pkg::SIG_INTR :
                      m_quit ? tcld_pkg::SIG_QUIT : tcld_pkg::SIG_SUSP;

    // line buffer
    logic [7:0]     r_line_mem [LINE_DEPTH];
    logic [7:0]     r_line_rd;
    logic [LNW-1:0] r_len, r_ci;
    logic           r_eof_mark;
    logic           line_full;

    assign line_full = (r_len == LINE_MAX);

    always_ff @(posedge i_clk) begin
        if (i_cmd.line_push && !line_full) begin
            r_line_mem[r_len[LIW-1:0]] <= r_c;
        end
        if (i_cmd.commit_rd) begin
            r_line_rd <= r_line_mem[r_ci[LIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_ci       <= '0;
            r_eof_mark <= 1'b0;
        end else begin
            if (i_cmd.line_push && !line_full) begin
                r_len <= r_len + 1'b1;
            end else if (i_cmd.line_pop) begin
                r_len <= r_len - 1'b1;
            end else if (i_cmd.commit_end) begin
                r_len <= '0;
            end
            if (i_cmd.commit_wr) begin
                r_ci <= r_ci + 1'b1;
            end else if (i_cmd.commit_end) begin
                r_ci <= '0;
            end
            if (i_cmd.commit_end && r_len == '0) begin
                r_eof_mark <= 1'b1;
            end else if (i_cmd.eof_clear) begin
                r_eof_mark <= 1'b0;
            end
        end
    end

    // input queue
    logic [7:0]    r_q_mem [RING_DEPTH];
    logic [7:0]    r_q_rd;
    logic [QW-1:0] r_head, r_tail;
    logic [QW-1:0] tail_nx, head_nx;
    logic          q_push;
    logic [7:0]    q_wdata;

    assign tail_nx = (r_tail == QLAST) ? '0 : r_tail + 1'b1;
    assign head_nx = (r_head == QLAST) ? '0 : r_head + 1'b1;
    assign q_push  = (i_cmd.queue_push_char || i_cmd.commit_wr) && (tail_nx != r_head);
    assign q_wdata = i_cmd.commit_wr ? r_line_rd : r_c;

    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q_mem[r_tail] <= q_wdata;
        end
        if (i_cmd.q_pop_rd) begin
            r_q_rd <= r_q_mem[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else begin
            if (q_push) begin
                r_tail <= tail_nx;
            end
            if (i_cmd.q_pop_rd) begin
                r_head <= head_nx;
            end
        end
    end

    // result register
    logic       r_out_valid;
    logic [2:0] r_kind;
    logic [7:0] r_data;
    logic [1:0] r_sig;
    logic       r_last;
    logic [7:0] out_byte;

    always_comb begin
        case (i_cmd.out_src)
            tcld_pkg::SRC_CHAR:  out_byte = r_c;
            tcld_pkg::SRC_CR:    out_byte = tcld_pkg::C_CR;
            tcld_pkg::SRC_BS:    out_byte = tcld_pkg::C_BS;
            tcld_pkg::SRC_SP:    out_byte = tcld_pkg::C_SP;
            tcld_pkg::SRC_QDATA: out_byte = r_q_rd;
            default:             out_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_kind <= i_cmd.out_kind;
            r_data <= out_byte;
            r_sig  <= (i_cmd.out_kind == tcld_pkg::KIND_SIGNAL) ? sig_code : '0;
            r_last <= i_cmd.out_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_data_byte   = r_data;
    assign o_signal_code = r_sig;
    assign o_last        = r_last;

    always_comb begin
        o_status.action      = r_act;
        o_status.is_sig      = r_mode[tcld_pkg::MF_SIG] && (m_intr || m_quit || m_susp);
        o_status.sig_target  = r_target;
        o_status.canon       = r_mode[tcld_pkg::MF_CANON];
        o_status.is_erase    = (r_c == r_erase) || (r_c == tcld_pkg::C_BS)
                               || (r_c == tcld_pkg::C_DEL);
        o_status.is_eof      = (r_c == r_eof);
        o_status.echo_on     = r_mode[tcld_pkg::MF_ECHO];
        o_status.is_nl       = (r_c == tcld_pkg::C_NL);
        o_status.crnl        = r_mode[tcld_pkg::MF_CRNL_OUT] && (r_c == tcld_pkg::C_NL);
        o_status.line_empty  = (r_len == '0);
        o_status.q_empty     = (r_head == r_tail);
        o_status.eof_mark    = r_eof_mark;
        o_status.commit_done = (r_ci == r_len);
        o_status.out_free    = !r_out_valid || !i_out_stall;
    end

endmodule

FILE: hdl/tty_canonical_line_discipline_top.sv
// Terminal line discipline for received bytes.
// Input channel (i_in_valid / o_in_stall): one word is either a received byte
// (i_action = 0) or a pop request (i_action = 1). A word is taken when valid
// is high and stall is low; the block takes one word at a time.
// Output channel (o_out_valid / i_out_stall): zero to three result words per
// input word, o_last marks the final one. Results wait in an output register,
// so the next input word can be taken while the last result is still stalled.
// The first result is registered by the output state that follows the
// decide state; each further result is loaded once the output register is
// free. A line commit (newline or EOF character in canonical mode) copies
// the line into the read queue one byte at a time through the line buffer
// read port, passing through the check, read and write states per byte.
// Configuration registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while the block is idle, since
// the block itself does not enforce this.
// Synchronous reset clears the line, the queue pointers and the EOF mark and
// restores the register defaults; no clearing pass is needed. A stalled
// receiver holds the current result and blocks the remaining ones.
`include "assert_macros.svh"

module tty_canonical_line_discipline_top #(
    parameter int RING_DEPTH = tcld_pkg::RING_DEPTH_DEF,
    parameter int LINE_DEPTH = tcld_pkg::LINE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_action,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_signal_code,
    output logic       o_last
);

    tcld_pkg::t_cmd    cmd;
    tcld_pkg::t_status status;

    tcld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcld_dp #(
        .RING_DEPTH (RING_DEPTH),
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_rx_byte     (i_rx_byte),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_kind        (o_kind),
        .o_data_byte   (o_data_byte),
        .o_signal_code (o_signal_code),
        .o_last        (o_last),
        .i_cmd         (cmd),
        .o_status      (status)
    );

    `TCLD_ASSERT(a_load_when_free, i_clk, i_rst_n, cmd.out_load |-> status.out_free)
    `TCLD_ASSERT(a_busy_after_take, i_clk, i_rst_n, (i_in_valid && !o_in_stall) |=> o_in_stall)
    `TCLD_ASSERT(a_commit_wr_after_rd, i_clk, i_rst_n, cmd.commit_wr |-> $past(cmd.commit_rd))
    `TCLD_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall)

endmodule
